// ===== rtl/core/cbs_pkg.sv =====
// Shared types and constants for the code block brace scanner.
// Used by every module in rtl/core; depends on nothing else.
package cbs_pkg;

  // Nesting limit default and the hard ceiling set by the 8-bit depth.
  localparam int unsigned CBS_MAX_NESTING = 255;
  localparam int unsigned CBS_DEPTH_CEIL  = 255;

  // Byte queue between front and back (power of two).
  localparam int unsigned CBS_QUEUE_DEPTH = 4;

  // Error codes reported on the result channel.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR_LIT = 2'd1;
  localparam logic [1:0] ERR_EOT      = 2'd2;
  localparam logic [1:0] ERR_NESTING  = 2'd3;

  // Byte classes produced by the front end.
  typedef enum logic [3:0] {
    CLS_OTHER   = 4'd0,
    CLS_ZERO    = 4'd1,
    CLS_DQUOTE  = 4'd2,
    CLS_SLASH   = 4'd3,
    CLS_STAR    = 4'd4,
    CLS_BSLASH  = 4'd5,
    CLS_QUOTE   = 4'd6,
    CLS_LBRACE  = 4'd7,
    CLS_RBRACE  = 4'd8,
    CLS_NEWLINE = 4'd9
  } cbs_cls_t;

  // Scanner modes.
  typedef enum logic [2:0] {
    MODE_NORMAL    = 3'd0,
    MODE_SLASH     = 3'd1,
    MODE_LINE      = 3'd2,
    MODE_BLOCK     = 3'd3,
    MODE_STRING    = 3'd4,
    MODE_CHR_FIRST = 3'd5,
    MODE_CHR_ESC   = 3'd6,
    MODE_CHR_CLOSE = 3'd7
  } cbs_mode_t;

  // Front end to queue: one classified request.
  typedef struct packed {
    logic     push;
    cbs_cls_t cls;
  } cbs_push_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    cbs_cls_t cls;
  } cbs_head_t;

endpackage

// ===== rtl/core/cbs_front.sv =====
// Front end of the brace scanner: input handshake and byte classification.
// Depends on cbs_pkg.
module cbs_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_in,
  input  logic               q_full,
  output cbs_pkg::cbs_push_t push
);
  import cbs_pkg::*;

  cbs_cls_t cls;

  // Accept whenever the queue has room
  assign in_ready = !q_full;

  // Map the byte onto the few classes the scanner cares about
  always_comb begin
    unique case (in_char_in)
      8'h00:   cls = CLS_ZERO;
      8'h22:   cls = CLS_DQUOTE;
      8'h2F:   cls = CLS_SLASH;
      8'h2A:   cls = CLS_STAR;
      8'h5C:   cls = CLS_BSLASH;
      8'h27:   cls = CLS_QUOTE;
      8'h7B:   cls = CLS_LBRACE;
      8'h7D:   cls = CLS_RBRACE;
      8'h0A:   cls = CLS_NEWLINE;
      default: cls = CLS_OTHER;
    endcase
  end

  assign push.push = in_valid && !q_full;
  assign push.cls  = cls;

endmodule

// ===== rtl/core/cbs_queue.sv =====
// Small FIFO of classified bytes between the front and back ends.
// Depends on cbs_pkg.
module cbs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cbs_pkg::cbs_push_t push,
  output logic               q_full,
  output cbs_pkg::cbs_head_t head,
  input  logic               pop
);
  import cbs_pkg::*;

  localparam int unsigned PTR_W = $clog2(CBS_QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(CBS_QUEUE_DEPTH + 1);

  cbs_cls_t           mem_r [CBS_QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_pop;

  assign q_full     = (count_r == CNT_W'(CBS_QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cls   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update; pointers wrap at the power-of-two depth
  always_comb begin
    wr_ptr_nxt = push.push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wr_ptr_r] <= push.cls;
    end
  end

endmodule

// ===== rtl/core/cbs_back.sv =====
// Back end of the brace scanner: scan state machine, depth counter and
// the registered result stage. Depends on cbs_pkg.
module cbs_back #(
  parameter int unsigned MAX_NESTING = cbs_pkg::CBS_MAX_NESTING
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbs_pkg::cbs_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_body,
  output logic               out_block_end,
  output logic [1:0]         out_error_code,
  output logic [7:0]         out_current_depth
);
  import cbs_pkg::*;

  // Effective limit is capped by the 8-bit depth counter
  localparam logic [7:0] DEPTH_LIMIT = (MAX_NESTING > CBS_DEPTH_CEIL) ?
                                       8'(CBS_DEPTH_CEIL) : 8'(MAX_NESTING);

  cbs_mode_t  mode_r, mode_nxt;
  logic       bs_r, bs_nxt;
  logic       star_r, star_nxt;
  logic [7:0] depth_r, depth_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       body_r, end_r;
  logic [1:0] err_r;
  logic [7:0] cdepth_r;

  logic       plain;
  logic [1:0] err;
  logic       blk_end;

  // Take a request when the result stage is empty or draining
  assign pop = head.valid && (!out_valid_r || out_ready);

  // Next scan state for the byte at the queue head
  always_comb begin
    mode_nxt  = mode_r;
    bs_nxt    = bs_r;
    star_nxt  = star_r;
    depth_nxt = depth_r;
    err       = ERR_NONE;
    blk_end   = 1'b0;
    plain     = 1'b0;

    if (head.cls == CLS_ZERO) begin
      err = ERR_EOT;
    end else begin
      unique case (mode_r)
        MODE_SLASH: begin
          if (head.cls == CLS_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (head.cls == CLS_STAR) begin
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else begin
            mode_nxt = MODE_NORMAL;
            plain    = 1'b1;
          end
        end
        MODE_LINE: begin
          if (head.cls == CLS_NEWLINE) mode_nxt = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (star_r && head.cls == CLS_SLASH) begin
            mode_nxt = MODE_NORMAL;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (head.cls == CLS_STAR);
          end
        end
        MODE_STRING: begin
          if (head.cls == CLS_DQUOTE && !bs_r) begin
            mode_nxt = MODE_NORMAL;
            bs_nxt   = 1'b0;
          end else begin
            bs_nxt = (head.cls == CLS_BSLASH);
          end
        end
        MODE_CHR_FIRST: begin
          mode_nxt = (head.cls == CLS_BSLASH) ? MODE_CHR_ESC : MODE_CHR_CLOSE;
        end
        MODE_CHR_ESC: begin
          mode_nxt = MODE_CHR_CLOSE;
        end
        MODE_CHR_CLOSE: begin
          if (head.cls == CLS_QUOTE) mode_nxt = MODE_NORMAL;
          else                       err = ERR_CHAR_LIT;
        end
        MODE_NORMAL: begin
          plain = 1'b1;
        end
      endcase
    end

    // Plain code: also covers the byte after a lone slash
    if (plain) begin
      unique case (head.cls)
        CLS_DQUOTE: begin
          mode_nxt = MODE_STRING;
          bs_nxt   = 1'b0;
        end
        CLS_SLASH: mode_nxt = MODE_SLASH;
        CLS_QUOTE: mode_nxt = MODE_CHR_FIRST;
        CLS_LBRACE: begin
          if (depth_r >= DEPTH_LIMIT) err = ERR_NESTING;
          else                        depth_nxt = depth_r + 8'd1;
        end
        CLS_RBRACE: begin
          depth_nxt = depth_r - 8'd1;
          if (depth_r == 8'd1) blk_end = 1'b1;
        end
        default: ;
      endcase
    end

    // Block end or error: back to the start of a new block
    if (err != ERR_NONE || blk_end) begin
      mode_nxt  = MODE_NORMAL;
      bs_nxt    = 1'b0;
      star_nxt  = 1'b0;
      depth_nxt = 8'd1;
    end
  end

  // Result stage occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)            out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      bs_r        <= 1'b0;
      star_r      <= 1'b0;
      depth_r     <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        mode_r  <= mode_nxt;
        bs_r    <= bs_nxt;
        star_r  <= star_nxt;
        depth_r <= depth_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (err != ERR_NONE || blk_end) begin
        body_r   <= 1'b0;
        end_r    <= blk_end;
        err_r    <= err;
        cdepth_r <= 8'd0;
      end else begin
        body_r   <= 1'b1;
        end_r    <= 1'b0;
        err_r    <= ERR_NONE;
        cdepth_r <= depth_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_in_body       = body_r;
  assign out_block_end     = end_r;
  assign out_error_code    = err_r;
  assign out_current_depth = cdepth_r;

endmodule

// ===== rtl/core/code_block_brace_scanner.sv =====
// Brace scanner for the bytes of a C-like code body, one byte per request,
// starting just after the opening brace. Each byte yields one result with
// body membership, block end, nesting depth and an error code; braces in
// strings, comments and character literals are ignored. Throughput is one
// byte per clock while the result side is not stalled, set by the mode and
// depth update the back end makes for each byte it takes. Each byte is
// written into the four-entry byte queue when accepted, then scanned from
// the queue head into the result register when popped. The queue lets
// input keep flowing for four bytes while the result side stalls.
// Depends on cbs_pkg, cbs_front, cbs_queue, cbs_back.
module code_block_brace_scanner #(
  parameter int unsigned MAX_NESTING = cbs_pkg::CBS_MAX_NESTING
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_in_body,
  output logic       out_block_end,
  output logic [1:0] out_error_code,
  output logic [7:0] out_current_depth
);
  import cbs_pkg::*;

  cbs_push_t push;
  cbs_head_t head;
  logic      q_full;
  logic      pop;

  // Classify and accept
  cbs_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .q_full     (q_full),
    .push       (push)
  );

  // Decoupling queue
  cbs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // Scan engine and result register
  cbs_back #(
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_in_body       (out_in_body),
    .out_block_end     (out_block_end),
    .out_error_code    (out_error_code),
    .out_current_depth (out_current_depth)
  );

endmodule
